FILE: hdl/checked_numeric_type_cast_top_assert.svh
// Assertion macros for the checked numeric type cast block.
// Used by the top level; needs a clock aclk and a reset aresetn in scope.
`ifndef CHECKED_NUMERIC_TYPE_CAST_TOP_ASSERT_SVH
`define CHECKED_NUMERIC_TYPE_CAST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CNTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("cast check failed");
`define CNTC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("cast reset check failed");
`else
`define CNTC_ASSERT(lbl, prop)
`define CNTC_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: hdl/cntc_pkg.sv
// Shared type codes and pipeline item type for the checked numeric type cast.
// No dependencies.
package cntc_pkg;
    localparam logic [2:0] TY_BOOL = 3'd0;
    localparam logic [2:0] TY_I32  = 3'd1;
    localparam logic [2:0] TY_I64  = 3'd2;
    localparam logic [2:0] TY_U64  = 3'd3;
    localparam logic [2:0] TY_F32  = 3'd4;
    localparam logic [2:0] TY_F64  = 3'd5;
    localparam logic [2:0] DEST_RESET = TY_I32;

    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_TOFP,
        KIND_FPINT
    } kind_t;

    typedef struct packed {
        logic [2:0]         dt;
        kind_t              kind;
        logic               err;
        logic [63:0]        res;
        logic               sign;
        logic [63:0]        mag;
        logic signed [12:0] e0;
        logic [5:0]         lz;
    } item_t;
endpackage

FILE: hdl/checked_numeric_type_cast_top.sv
// Top level of the checked numeric type cast: four-stage conversion pipeline.
// Depends on cntc_pkg, cntc_lzc and checked_numeric_type_cast_top_assert.svh.
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     s_func, s_source_bits
//  m_        out        m_valid / m_ready     m_result_bits, m_cast_error
//  cfg_      in         cfg_wr_en             cfg_wr_data (dest_type)
//
// One item per cycle while m_ready stays high; m_valid rises once the item reaches the fourth stage register.
// Stages: decode and integer checks, zero count and float-to-integer check,
// normalize, round and pack into the output register.
// Synchronous active-low reset clears stage valids and sets dest_type to int32.
// Each stage holds only while the stage after it is full and stalled.
module checked_numeric_type_cast_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [63:0] s_source_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_bits,
    output logic        m_cast_error
);
    `include "checked_numeric_type_cast_top_assert.svh"

    logic [2:0] dest_type_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    cntc_pkg::item_t d1_reg, d2_reg, d3_reg, d4_reg;
    cntc_pkg::item_t d1_next, d2_next, d3_next, d4_next;
    logic [5:0] lz_w;

    function automatic logic [63:0] type_mask(input logic [2:0] t);
        if (t == cntc_pkg::TY_BOOL) return 64'd1;
        if (t == cntc_pkg::TY_I32 || t == cntc_pkg::TY_F32) return 64'h0000_0000_FFFF_FFFF;
        return '1;
    endfunction

    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_type_reg <= cntc_pkg::DEST_RESET;
        end else if (cfg_wr_en) begin
            dest_type_reg <= cfg_wr_data;
        end
    end

    // stage 1: decode
    always_comb begin
        logic [2:0]  st;
        logic [2:0]  dt;
        logic [63:0] b;
        logic [31:0] u;
        logic        ineg;
        logic [63:0] imag;
        logic        fits;
        logic        fs;
        logic [10:0] fe;
        logic [51:0] ff;
        logic        fnan, finf, fzero;
        logic        dst_fp;
        st = s_func;
        dt = dest_type_reg;
        b  = s_source_bits;
        u  = b[31:0];
        ineg = 1'b0;
        imag = 64'd0;
        fits = 1'b0;
        d1_next = '0;
        d1_next.dt = dt;
        d1_next.kind = cntc_pkg::KIND_DONE;
        unique case (st)
            cntc_pkg::TY_BOOL: imag = {63'd0, b[0]};
            cntc_pkg::TY_I32: begin
                ineg = u[31];
                imag = ineg ? (64'h1_0000_0000 - {32'd0, u}) : {32'd0, u};
            end
            cntc_pkg::TY_I64: begin
                ineg = b[63];
                imag = ineg ? (64'd0 - b) : b;
            end
            default: imag = b;
        endcase
        if (st == cntc_pkg::TY_F32) begin
            fs = b[31];
            fe = {3'd0, b[30:23]};
            ff = {b[22:0], 29'd0};
            fnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
            finf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
            fzero = (b[30:0] == 31'd0);
            d1_next.e0 = (b[30:23] == 8'd0) ? -13'sd126 : $signed({2'b0, fe}) - 13'sd127;
        end else begin
            fs = b[63];
            fe = b[62:52];
            ff = b[51:0];
            fnan = (fe == 11'h7FF) && (ff != 52'd0);
            finf = (fe == 11'h7FF) && (ff == 52'd0);
            fzero = (b[62:0] == 63'd0);
            d1_next.e0 = (fe == 11'd0) ? -13'sd1022 : $signed({2'b0, fe}) - 13'sd1023;
        end
        dst_fp = (dt == cntc_pkg::TY_F32) || (dt == cntc_pkg::TY_F64);
        if (st > cntc_pkg::TY_F64 || dt > cntc_pkg::TY_F64) begin
            d1_next.err = 1'b1;
        end else if (st == dt) begin
            d1_next.res = b & type_mask(st);
        end else if (st <= cntc_pkg::TY_U64) begin
            d1_next.sign = ineg;
            d1_next.mag = imag;
            d1_next.e0 = 13'sd63;
            if (dst_fp) begin
                if (imag != 64'd0) begin
                    d1_next.kind = cntc_pkg::KIND_TOFP;
                end
            end else begin
                unique case (dt)
                    cntc_pkg::TY_BOOL: fits = !ineg && imag <= 64'd1;
                    cntc_pkg::TY_I32:  fits = ineg ? imag <= 64'h8000_0000
                                                   : imag <= 64'h7FFF_FFFF;
                    cntc_pkg::TY_I64:  fits = ineg ? imag <= 64'h8000_0000_0000_0000
                                                   : imag <= 64'h7FFF_FFFF_FFFF_FFFF;
                    default:           fits = !ineg;
                endcase
                d1_next.err = !fits;
                d1_next.res = fits ? ((ineg ? (64'd0 - imag) : imag) & type_mask(dt)) : 64'd0;
            end
        end else begin
            d1_next.sign = fs;
            d1_next.mag = {fe != 11'd0, ff, 11'd0};
            if (dst_fp) begin
                if (st == cntc_pkg::TY_F32) begin
                    priority if (fnan) begin
                        d1_next.res = {fs, 11'h7FF, 1'b1, ff[50:0]};
                    end else if (finf) begin
                        d1_next.res = {fs, 11'h7FF, 52'd0};
                    end else if (fzero) begin
                        d1_next.res = {fs, 63'd0};
                    end else begin
                        d1_next.kind = cntc_pkg::KIND_TOFP;
                    end
                end else begin
                    priority if (fnan) begin
                        d1_next.res = {32'd0, fs, 8'hFF, 1'b1, ff[50:29]};
                    end else if (finf) begin
                        d1_next.res = {32'd0, fs, 8'hFF, 23'd0};
                    end else if (fzero) begin
                        d1_next.res = {32'd0, fs, 31'd0};
                    end else begin
                        d1_next.kind = cntc_pkg::KIND_TOFP;
                    end
                end
            end else if (fnan || finf) begin
                d1_next.err = 1'b1;
            end else begin
                d1_next.kind = cntc_pkg::KIND_FPINT;
            end
        end
    end

    // stage 2: zero count, float-to-integer truncation and check
    cntc_lzc u_lzc (
        .val (d1_reg.mag),
        .lz  (lz_w)
    );

    always_comb begin
        logic signed [12:0] sh;
        logic [63:0] t;
        logic        ovf;
        logic        nz;
        logic        fits;
        sh = 13'sd63 - d1_reg.e0;
        t = 64'd0;
        ovf = 1'b0;
        fits = 1'b0;
        nz = d1_reg.mag != 64'd0;
        if (d1_reg.e0 > 13'sd63) begin
            ovf = 1'b1;
        end else if (d1_reg.e0 >= 13'sd0) begin
            t = d1_reg.mag >> sh[5:0];
        end
        d2_next = d1_reg;
        d2_next.lz = lz_w;
        if (d1_reg.kind == cntc_pkg::KIND_FPINT) begin
            d2_next.kind = cntc_pkg::KIND_DONE;
            unique case (d1_reg.dt)
                cntc_pkg::TY_BOOL: fits = !(d1_reg.sign && nz) && !ovf && t <= 64'd1;
                cntc_pkg::TY_I32:  fits = !ovf && (d1_reg.sign ? t <= 64'h8000_0000
                                                               : t < 64'h8000_0000);
                cntc_pkg::TY_I64:  fits = !ovf && (d1_reg.sign
                                                   ? t <= 64'h8000_0000_0000_0000
                                                   : t < 64'h8000_0000_0000_0000);
                default:           fits = !(d1_reg.sign && nz) && !ovf;
            endcase
            d2_next.err = !fits;
            if (!fits) begin
                d2_next.res = 64'd0;
            end else if (d1_reg.dt == cntc_pkg::TY_BOOL) begin
                d2_next.res = {63'd0, nz};
            end else begin
                d2_next.res = (d1_reg.sign ? (64'd0 - t) : t) & type_mask(d1_reg.dt);
            end
        end
    end

    // stage 3: normalize
    always_comb begin
        d3_next = d2_reg;
        if (d2_reg.kind == cntc_pkg::KIND_TOFP) begin
            d3_next.mag = d2_reg.mag << d2_reg.lz;
            d3_next.e0 = d2_reg.e0 - $signed({7'd0, d2_reg.lz});
        end
    end

    // stage 4: round and pack
    always_comb begin
        logic               dbl;
        logic signed [12:0] emin, bias, maxf, base, rs13, biased;
        logic               under;
        logic [6:0]         rs;
        logic [127:0]       wide;
        logic [63:0]        m;
        logic [63:0]        sum;
        logic [10:0]        expterm;
        logic               inf;
        dbl = d3_reg.dt == cntc_pkg::TY_F64;
        emin = dbl ? -13'sd1022 : -13'sd126;
        bias = dbl ? 13'sd1023 : 13'sd127;
        maxf = dbl ? 13'sd2047 : 13'sd255;
        base = dbl ? 13'sd11 : 13'sd40;
        under = d3_reg.e0 < emin;
        rs13 = base + (under ? (emin - d3_reg.e0) : 13'sd0);
        rs = (rs13 > 13'sd127) ? 7'd127 : rs13[6:0];
        wide = {d3_reg.mag, 64'd0} >> rs;
        m = wide[127:64] + {63'd0, wide[63] && ((|wide[62:0]) || wide[64])};
        biased = d3_reg.e0 + bias;
        inf = biased >= maxf;
        expterm = under ? 11'd0 : 11'(biased - 13'sd1);
        if (dbl) begin
            sum = 64'({expterm, 52'd0}) + m;
        end else begin
            sum = 64'({expterm[7:0], 23'd0}) + m;
        end
        d4_next = d3_reg;
        if (d3_reg.kind == cntc_pkg::KIND_TOFP) begin
            d4_next.kind = cntc_pkg::KIND_DONE;
            if (dbl) begin
                d4_next.res = inf ? {d3_reg.sign, 11'h7FF, 52'd0} : {d3_reg.sign, sum[62:0]};
            end else begin
                d4_next.res = inf ? {32'd0, d3_reg.sign, 8'hFF, 23'd0}
                                  : {32'd0, d3_reg.sign, sum[30:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) d1_reg <= d1_next;
        if (en2) d2_reg <= d2_next;
        if (en3) d3_reg <= d3_next;
        if (en4) d4_reg <= d4_next;
    end

    assign m_valid = v4_reg;
    assign m_result_bits = d4_reg.err ? 64'd0 : d4_reg.res;
    assign m_cast_error = d4_reg.err;

    `CNTC_ASSERT(a_err_zero, m_valid && m_cast_error |-> m_result_bits == 64'd0)
    `CNTC_ASSERT(a_advance, v3_reg && en4 |=> v4_reg)
    `CNTC_ASSERT(a_bad_dest, s_valid && s_ready && dest_type_reg > cntc_pkg::TY_F64 |=> d1_reg.err)
    `CNTC_ASSERT(a_f32_high, m_valid && d4_reg.dt == cntc_pkg::TY_F32 && !d4_reg.err |-> m_result_bits[63:32] == 32'd0)
    `CNTC_ASSERT_RST(a_reset_clear, !aresetn |=> !m_valid)
endmodule

FILE: hdl/cntc_lzc.sv
// Leading zero counter over a 64-bit word, built from eight byte groups.
// No dependencies.
module cntc_lzc (
    input  logic [63:0] val,
    output logic [5:0]  lz
);
    logic [7:0] grp_nz;
    logic [2:0] grp_lz [8];

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            grp_nz[g] = |val[g*8 +: 8];
            grp_lz[g] = 3'd7;
            for (int b = 0; b < 8; b++) begin
                if (val[g*8 + b]) begin
                    grp_lz[g] = 3'(7 - b);
                end
            end
        end
    end

    always_comb begin
        lz = 6'd63;
        for (int g = 0; g < 8; g++) begin
            if (grp_nz[g]) begin
                lz = {3'(7 - g), grp_lz[g]};
            end
        end
    end
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for checked_numeric_type_cast_top: random and directed casts.
// Depends on cntc_pkg and the block's RTL; a scoreboard class predicts each result.
module testbench;

    class cast_scoreboard;
        bit [2:0]  dest;
        bit [63:0] want_bits[$];
        bit        want_err[$];

        function new();
            dest = cntc_pkg::DEST_RESET;
        endfunction

        function bit [63:0] round_shift(bit [63:0] v, int s);
            bit [63:0] m, rem, half;
            m = v >> s;
            rem = v & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && m[0])) m = m + 1;
            return m;
        endfunction

        function int top_bit(bit [63:0] v);
            int p;
            p = 63;
            while (p > 0 && !v[p]) p--;
            return p;
        endfunction

        function bit [63:0] int_to_fp(bit neg, bit [63:0] mag, bit dbl);
            int mb, bias, p;
            bit [63:0] m, sgn;
            mb = dbl ? 52 : 23;
            bias = dbl ? 1023 : 127;
            sgn = neg ? (dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000) : 64'd0;
            if (mag == 0) return 64'd0;
            p = top_bit(mag);
            if (p <= mb) begin
                m = mag << (mb - p);
            end else begin
                m = round_shift(mag, p - mb);
                if ((m >> (mb + 1)) != 0) begin
                    m = m >> 1;
                    p++;
                end
            end
            return sgn | (64'(p + bias) << mb) | (m & ((64'd1 << mb) - 1));
        endfunction

        function bit [63:0] to_single(bit [63:0] d);
            bit [63:0] sgn, f, sig, m;
            int e, ex, s;
            sgn = {32'd0, d[63], 31'd0};
            e = d[62:52];
            f = {12'd0, d[51:0]};
            if (e == 2047)
                return (f != 0) ? (sgn | 64'h7FC0_0000 | (f >> 29)) : (sgn | 64'h7F80_0000);
            if (e == 0) return sgn;
            sig = f | (64'd1 << 52);
            ex = e - 1023;
            if (ex >= -126) begin
                m = round_shift(sig, 29);
                if ((m >> 24) != 0) begin
                    m = m >> 1;
                    ex++;
                end
                if (ex > 127) return sgn | 64'h7F80_0000;
                return sgn | (64'(ex + 127) << 23) | (m & 64'h7F_FFFF);
            end
            s = -(ex + 97);
            if (s > 60) return sgn;
            return sgn | round_shift(sig, s);
        endfunction

        function bit [63:0] to_double(bit [31:0] w);
            bit [63:0] sgn, f;
            int e, p;
            sgn = {w[31], 63'd0};
            e = w[30:23];
            f = {41'd0, w[22:0]};
            if (e == 255)
                return (f != 0) ? (sgn | 64'h7FF8_0000_0000_0000 | (f << 29))
                                : (sgn | 64'h7FF0_0000_0000_0000);
            if (e == 0) begin
                if (f == 0) return sgn;
                p = top_bit(f);
                return sgn | (64'(p + 1023 - 149) << 52) | ((f << (52 - p)) & 64'hF_FFFF_FFFF_FFFF);
            end
            return sgn | (64'(e - 127 + 1023) << 52) | (f << 29);
        endfunction

        function bit [63:0] trunc_mag(bit [63:0] d);
            int e;
            bit [63:0] sig;
            e = int'(d[62:52]) - 1023;
            if (e < 0) return 64'd0;
            sig = {12'd1, d[51:0]};
            return (e >= 52) ? (sig << (e - 52)) : (sig >> (52 - e));
        endfunction

        function bit fp_to_int(bit [2:0] st, bit [2:0] dt, bit [63:0] b, output bit [63:0] r);
            bit [63:0] d, mag, v;
            real x, lo, hi, top;
            int sh;
            d = (st == cntc_pkg::TY_F64) ? b : to_double(b[31:0]);
            r = 0;
            if (d[62:52] == 11'h7FF && d[51:0] != 0) return 0;
            x = $bitstoreal(d);
            top = (st == cntc_pkg::TY_F64) ? (2.0 - 2.0 ** -52) : (2.0 - 2.0 ** -23);
            case (dt)
                cntc_pkg::TY_BOOL: sh = 0;
                cntc_pkg::TY_I32:  sh = 30;
                cntc_pkg::TY_I64:  sh = 62;
                default: sh = 63;
            endcase
            hi = top * (2.0 ** sh);
            if (dt == cntc_pkg::TY_I32)
                lo = (st == cntc_pkg::TY_F64) ? -(2.0 ** 31 + 1.0 - 2.0 ** -21) : -(2.0 ** 31);
            else if (dt == cntc_pkg::TY_I64) lo = -(2.0 ** 63);
            else lo = 0.0;
            if (!(lo <= x && x <= hi)) return 0;
            if (dt == cntc_pkg::TY_BOOL) begin
                r = (d[62:0] != 0);
            end else begin
                mag = trunc_mag(d);
                v = d[63] ? -mag : mag;
                r = (dt == cntc_pkg::TY_I32) ? {32'd0, v[31:0]} : v;
            end
            return 1;
        endfunction

        function void note_input(bit [2:0] st, bit [63:0] b);
            bit [63:0] res, mag, v;
            bit err, neg, fits;
            bit [2:0] dt;
            dt = dest;
            res = 0;
            err = 0;
            neg = 0;
            if (st > cntc_pkg::TY_F64 || dt > cntc_pkg::TY_F64) begin
                err = 1;
            end else if (st == dt) begin
                if (st == cntc_pkg::TY_BOOL) res = b & 64'd1;
                else if (st == cntc_pkg::TY_I32 || st == cntc_pkg::TY_F32)
                    res = {32'd0, b[31:0]};
                else res = b;
            end else if (st <= cntc_pkg::TY_U64) begin
                if (st == cntc_pkg::TY_BOOL) begin
                    mag = b & 64'd1;
                end else if (st == cntc_pkg::TY_I32) begin
                    neg = b[31];
                    mag = neg ? (64'h1_0000_0000 - {32'd0, b[31:0]}) : {32'd0, b[31:0]};
                end else if (st == cntc_pkg::TY_I64) begin
                    neg = b[63];
                    mag = neg ? -b : b;
                end else begin
                    mag = b;
                end
                if (dt == cntc_pkg::TY_F32 || dt == cntc_pkg::TY_F64) begin
                    res = int_to_fp(neg, mag, dt == cntc_pkg::TY_F64);
                end else begin
                    if (dt == cntc_pkg::TY_BOOL) fits = !neg && mag <= 1;
                    else if (dt == cntc_pkg::TY_I32)
                        fits = neg ? mag <= 64'h8000_0000 : mag <= 64'h7FFF_FFFF;
                    else if (dt == cntc_pkg::TY_I64)
                        fits = neg ? mag <= 64'h8000_0000_0000_0000
                                   : mag <= 64'h7FFF_FFFF_FFFF_FFFF;
                    else fits = !neg;
                    if (!fits) begin
                        err = 1;
                    end else begin
                        v = neg ? -mag : mag;
                        if (dt == cntc_pkg::TY_BOOL) res = v & 64'd1;
                        else if (dt == cntc_pkg::TY_I32) res = {32'd0, v[31:0]};
                        else res = v;
                    end
                end
            end else if (dt == cntc_pkg::TY_F32 || dt == cntc_pkg::TY_F64) begin
                res = (st == cntc_pkg::TY_F32) ? to_double(b[31:0]) : to_single(b);
            end else begin
                err = !fp_to_int(st, dt, b, res);
            end
            want_bits.push_back(err ? 64'd0 : res);
            want_err.push_back(err);
        endfunction

        function bit check_result(bit [63:0] got_bits, bit got_err, output string msg);
            bit [63:0] eb;
            bit ee;
            if (want_bits.size() == 0) begin
                msg = $sformatf("unexpected result %h err %0b", got_bits, got_err);
                return 0;
            end
            eb = want_bits.pop_front();
            ee = want_err.pop_front();
            if (eb !== got_bits || ee !== got_err) begin
                msg = $sformatf("result %h err %0b, expected %h err %0b", got_bits, got_err, eb, ee);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_wr_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_func = 0;
    logic [63:0] s_source_bits = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [63:0] m_result_bits;
    logic        m_cast_error;

    cast_scoreboard sb = new();
    int  mismatches = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;

    checked_numeric_type_cast_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_source_bits(s_source_bits),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_bits(m_result_bits), .m_cast_error(m_cast_error)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        string msg;
        if (aresetn && s_valid && s_ready) sb.note_input(s_func, s_source_bits);
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_result(m_result_bits, m_cast_error, msg)) report(msg);
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 0;
                repeat (200) @(posedge aclk);
                hold_done = 1;
            end
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    task send_item(bit [2:0] f, bit [63:0] b, int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= f;
        s_source_bits <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task drain_and_set(bit [2:0] d);
        s_valid <= 0;
        @(posedge aclk);
        while (sb.want_bits.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.dest = d;
    endtask

    function bit [63:0] make_bits(bit [2:0] f);
        bit [63:0] b;
        bit [63:0] corners[10];
        corners = '{64'd0, 64'd1, 64'd2, 64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF,
                    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '1, 64'hFFFF_FFFF_8000_0000};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: ;
            1: b = {{56{b[7]}}, b[7:0]};
            2: b = corners[$urandom_range(0, 9)] ^ 64'($urandom_range(0, 1));
            3: begin
                if (f == cntc_pkg::TY_F32) b[30:23] = 8'(127 + $urandom_range(0, 66) - 2);
                else b[62:52] = 11'(1023 + $urandom_range(0, 66) - 2);
            end
            4: begin
                if (f == cntc_pkg::TY_F32) b[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else b[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
                if ($urandom_range(0, 1)) b[51:0] = 0;
                if ($urandom_range(0, 1)) b[22:0] = 0;
            end
            5: b[62:52] = 11'(1023 - 126 - $urandom_range(0, 60));
            6: b = 64'($urandom_range(0, 3)) << $urandom_range(0, 63);
            default: b[62:52] = 11'(1023 + $urandom_range(0, 130) - 65);
        endcase
        return b;
    endfunction

    initial begin
        bit [2:0] dests[9];
        bit [2:0] f;
        dests = '{cntc_pkg::TY_BOOL, cntc_pkg::TY_F64, cntc_pkg::TY_U64, cntc_pkg::TY_F32,
                  cntc_pkg::TY_I64, cntc_pkg::TY_I32, 3'd7, cntc_pkg::TY_F64,
                  cntc_pkg::TY_BOOL};
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: default int32 target
        send_item(cntc_pkg::TY_I32, 64'hFFFF_FFFF_8000_0000, 0);
        send_item(cntc_pkg::TY_I64, 64'h0000_0000_7FFF_FFFF, 0);
        send_item(cntc_pkg::TY_I64, 64'h0000_0000_8000_0000, 0);
        send_item(cntc_pkg::TY_I64, 64'hFFFF_FFFF_8000_0000, 1);
        send_item(cntc_pkg::TY_I64, 64'hFFFF_FFFF_7FFF_FFFF, 0);
        send_item(cntc_pkg::TY_U64, '1, 0);
        send_item(cntc_pkg::TY_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 0);
        send_item(cntc_pkg::TY_F32, 64'h4EFF_FFFF, 0);
        send_item(cntc_pkg::TY_F32, 64'h4F00_0000, 2);
        send_item(cntc_pkg::TY_F32, 64'hCF00_0000, 0);
        send_item(cntc_pkg::TY_F32, 64'h7FC0_0000, 0);
        send_item(cntc_pkg::TY_F64, 64'hC1E0_0000_0020_0000, 0);
        send_item(cntc_pkg::TY_F64, 64'hC1E0_0000_001F_FFFF, 0);
        send_item(cntc_pkg::TY_F64, 64'hBFE0_0000_0000_0000, 0);
        send_item(cntc_pkg::TY_F64, 64'h7FF0_0000_0000_0000, 0);
        send_item(3'd6, '1, 0);
        send_item(3'd7, 64'd0, 0);
        drain_and_set(cntc_pkg::TY_BOOL);
        send_item(cntc_pkg::TY_F64, 64'h8000_0000_0000_0000, 0);
        send_item(cntc_pkg::TY_F64, 64'hBFE0_0000_0000_0000, 0);
        send_item(cntc_pkg::TY_F32, 64'h3FFF_FFFF, 0);
        drain_and_set(cntc_pkg::TY_F32);
        send_item(cntc_pkg::TY_F64, 64'h7FF0_0000_0000_0001, 0);
        send_item(cntc_pkg::TY_F64, 64'h3690_0000_0000_0001, 0);
        send_item(cntc_pkg::TY_U64, '1, 0);
        for (int ph = 0; ph < 9; ph++) begin
            drain_and_set(dests[ph]);
            if (ph == 2) begin
                hold_req = 1;
                repeat (60) send_item(cntc_pkg::TY_U64, {$urandom, $urandom}, 0);
            end
            repeat (85) begin
                f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
                send_item(f, make_bits(f), pick_gap());
            end
        end
        s_valid <= 0;
        @(posedge aclk);
        while (sb.want_bits.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/cntc_pkg.sv
hdl/cntc_lzc.sv
hdl/checked_numeric_type_cast_top.sv
verif/testbench.sv
